FILE: design/b64u_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_pkg
// shared types, constants and the character table of the base64url encoder
// ----------------------------------------------------------------------------
package b64u_pkg;

    localparam int MAX_GROUPS_DEF  = 63;
    localparam int QUEUE_DEPTH     = 4;
    localparam logic [7:0] MAX_CHARS_RST = 8'd43;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

    localparam logic [6:0] ASCII_UPPER_A = 7'h41;
    localparam logic [6:0] ASCII_LOWER_A = 7'h61;
    localparam logic [6:0] ASCII_ZERO    = 7'h30;
    localparam logic [6:0] ASCII_MINUS   = 7'h2D;
    localparam logic [6:0] ASCII_UNDER   = 7'h5F;

    typedef struct packed {
        logic [1:0] cnt;
        logic [5:0] six0;
        logic [5:0] six1;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [6:0] six_to_char(input logic [5:0] six);
        logic [6:0] s;
        logic [6:0] c;
        begin
            s = {1'b0, six};
            if (six < 6'd26)
            begin
                c = ASCII_UPPER_A + s;
            end
            else if (six < 6'd52)
            begin
                c = ASCII_LOWER_A + s - 7'd26;
            end
            else if (six < 6'd62)
            begin
                c = ASCII_ZERO + s - 7'd52;
            end
            else if (six == 6'd62)
            begin
                c = ASCII_MINUS;
            end
            else
            begin
                c = ASCII_UNDER;
            end
            return c;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/b64u_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_front
// accepts bytes, tracks group phase and character budget, queues the values
// ----------------------------------------------------------------------------
module b64u_front #(
    parameter int MAX_GROUPS = b64u_pkg::MAX_GROUPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [7:0]         cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    input  wire b64u_pkg::fifo_stat_t stat,
    output logic                    push,
    output b64u_pkg::entry_t        push_data
);
    import b64u_pkg::*;

    localparam int GW = $clog2(MAX_GROUPS + 1);
    localparam logic [GW-1:0] GROUP_LIMIT = GW'(MAX_GROUPS);

    logic [7:0]    max_chars_reg;
    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    left_reg, left_next;
    logic [GW-1:0] groups_reg, groups_next;
    logic [7:0]    chars_reg, chars_next;

    logic       accept;
    logic       active;
    logic       want1;
    logic       ok0, ok1;
    logic [5:0] v0, v1;

    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;
    assign active   = groups_reg < GROUP_LIMIT;

    always_comb
    begin
        phase_next  = phase_reg;
        left_next   = left_reg;
        groups_next = groups_reg;
        case (phase_reg)
            PHASE_0:
            begin
                v0    = data_byte[7:2];
                v1    = {data_byte[1:0], 4'b0};
                want1 = last_byte;
                if (active)
                begin
                    phase_next = PHASE_1;
                    left_next  = {2'b0, data_byte[1:0]};
                end
            end
            PHASE_1:
            begin
                v0    = {left_reg[1:0], data_byte[7:4]};
                v1    = {data_byte[3:0], 2'b0};
                want1 = last_byte;
                if (active)
                begin
                    phase_next = PHASE_2;
                    left_next  = data_byte[3:0];
                end
            end
            default:
            begin
                v0    = {left_reg, data_byte[7:6]};
                v1    = data_byte[5:0];
                want1 = 1'b1;
                if (active)
                begin
                    phase_next  = PHASE_0;
                    left_next   = 4'b0;
                    groups_next = groups_reg + GW'(1);
                end
            end
        endcase

        ok0 = active && (chars_reg < max_chars_reg);
        ok1 = active && want1 && (({1'b0, chars_reg} + 9'd1) < {1'b0, max_chars_reg});
        chars_next = chars_reg + {7'b0, ok0} + {7'b0, ok1};

        if (last_byte)
        begin
            phase_next  = PHASE_0;
            left_next   = 4'b0;
            groups_next = '0;
            chars_next  = 8'd0;
        end

        push_data.six0 = v0;
        push_data.six1 = v1;
        push_data.last = last_byte;
        if (ok1)
        begin
            push_data.cnt = CNT_TWO;
        end
        else if (ok0)
        begin
            push_data.cnt = CNT_ONE;
        end
        else
        begin
            push_data.cnt = CNT_NONE;
        end
        push = accept && (ok0 || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_chars_reg <= MAX_CHARS_RST;
            phase_reg     <= PHASE_0;
            left_reg      <= 4'b0;
            groups_reg    <= '0;
            chars_reg     <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_chars_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                phase_reg  <= phase_next;
                left_reg   <= left_next;
                groups_reg <= groups_next;
                chars_reg  <= chars_next;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/b64u_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_fifo
// short queue of staged character pairs between front and back
// ----------------------------------------------------------------------------
module b64u_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire b64u_pkg::entry_t     push_data,
    input  wire logic                 pop,
    output b64u_pkg::entry_t          head,
    output b64u_pkg::fifo_stat_t      stat
);
    import b64u_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    entry_t        mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = count_reg == FULL_CNT;
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/b64u_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64u_back
// drains queued entries one character per beat into the output register
// ----------------------------------------------------------------------------
module b64u_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire b64u_pkg::entry_t     head,
    input  wire b64u_pkg::fifo_stat_t stat,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [6:0]                out_char,
    output logic                      char_valid,
    output logic                      end_of_text
);
    import b64u_pkg::*;

    logic       idx_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       char_valid_reg;
    logic       end_reg;

    logic       load;
    logic       final_beat;
    logic [5:0] six;

    assign load       = !stat.empty && (!out_valid_reg || out_ready);
    assign final_beat = (head.cnt != CNT_TWO) || idx_reg;
    assign six        = idx_reg ? head.six1 : head.six0;
    assign pop        = load && final_beat;

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign char_valid  = char_valid_reg;
    assign end_of_text = end_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg   <= (head.cnt == CNT_NONE) ? 7'd0 : six_to_char(six);
            char_valid_reg <= head.cnt != CNT_NONE;
            end_reg        <= head.last && final_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= !final_beat;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/base64url_stream_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64url_stream_encoder_core
// url-safe base64 encoder without padding, one byte in, characters out
// ----------------------------------------------------------------------------
// input channel: in_valid/in_ready carry one byte per beat, last_byte on the
// final byte of a message. output channel: out_valid/out_ready carry one
// character per beat with char_valid and end_of_text.
// cfg_wr_en/cfg_wr_data write max_chars (reset 43) between messages.
// a byte yields zero, one or two characters; a final byte with nothing to
// send yields one beat with char_valid low and end_of_text high.
// the first character of a byte passes through the queue and then the
// output register. throughput: one byte per cycle for bytes of at most
// one character while out_ready is high, set by the single output
// register sending one character per beat from the four-deep queue.
// a stalled receiver holds the output register; the front keeps taking
// bytes until the queue fills, then drops in_ready.
// reset clears phase, carry bits, group and character counts, the queue
// and the output valid flag, but not out_char, char_valid or end_of_text.
// ----------------------------------------------------------------------------
module base64url_stream_encoder_core #(
    parameter int MAX_GROUPS = b64u_pkg::MAX_GROUPS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      out_char,
    output logic            char_valid,
    output logic            end_of_text
);
    import b64u_pkg::*;

    logic       push, pop;
    entry_t     push_data, head;
    fifo_stat_t stat;

    b64u_front #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .stat        (stat),
        .push        (push),
        .push_data   (push_data)
    );

    b64u_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    b64u_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_char    (out_char),
        .char_valid  (char_valid),
        .end_of_text (end_of_text)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("queue read while empty");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !char_valid) |-> (end_of_text && out_char == 7'd0))
        else $error("empty beat without end marker");

    a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.full && !pop) |=> !stat.empty)
        else $error("full queue lost entries");

endmodule
`default_nettype wire
